// File: rtl/slc_pkg.sv
// Shared widths, reset values, register indexes and interface types of the linearity corrector.
`default_nettype none

package slc_pkg;

    localparam int GAIN_W      = 32;
    localparam int PIXCNT_W    = 11;
    localparam int ORD_W       = 3;
    localparam int COEF_W      = 48;
    localparam int NUM_COEFS   = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 48;
    localparam int MAC_A_W     = 32;
    localparam int MAC_B_W     = 16;
    localparam int MAC_IDX_W   = 3;
    localparam int ACC_W       = 112;
    localparam int HORNER_W    = 64;
    localparam int DIVISOR_W   = 63;
    localparam int OUT_W       = 32;
    localparam int PIX_IDX_W   = 10;

    localparam int MAX_PIXELS_DEF    = 1024;
    localparam int SYNC_INTERVAL_DEF = 512;
    localparam int MAX_ORDER_DEF     = 4;

    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(65536);
    localparam logic [PIXCNT_W-1:0] PIXCNT_RST = PIXCNT_W'(512);
    localparam logic [ORD_W-1:0]    ORD_RST    = '0;
    localparam logic [COEF_W-1:0]   COEF0_RST  = COEF_W'(64'd1 << 40);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_GAIN  = 3'd0,
        REG_PIXEL_COUNT = 3'd1,
        REG_POLY_ORDER  = 3'd2,
        REG_COEF_0      = 3'd3,
        REG_COEF_1      = 3'd4,
        REG_COEF_2      = 3'd5,
        REG_COEF_3      = 3'd6,
        REG_COEF_4      = 3'd7
    } cfg_reg_t;

    typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_arr_t;

    // One product request to the shared multiply-accumulate unit.
    typedef struct packed {
        logic                 issue;
        logic                 clear;
        logic [MAC_IDX_W-1:0] idx;
        logic [MAC_A_W-1:0]   a;
        logic [MAC_B_W-1:0]   b;
    } mac_cmd_t;

    typedef struct packed {
        logic                 start;
        logic [PROD_W-1:0]    dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             valid;
        logic             fault;
        logic [OUT_W-1:0] value;
    } slc_res_t;

endpackage

`default_nettype wire

// File: rtl/slc_mac.sv
// Shared 32x16 multiplier with a registered product and a 112-bit shifting accumulator.
`default_nettype none

module slc_mac (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire slc_pkg::mac_cmd_t           cmd,
    output logic [slc_pkg::ACC_W-1:0]        acc
);
    import slc_pkg::*;

    logic [PROD_W-1:0]    prod_reg;
    logic [MAC_IDX_W-1:0] idx_reg;
    logic                 vld_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [ACC_W-1:0]     shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            prod_reg <= PROD_W'(cmd.a) * PROD_W'(cmd.b);
            idx_reg  <= cmd.idx;
        end
        acc_reg <= acc_next;
    end

    // Each partial product lands at a multiple of 16 bits.
    assign shifted  = ACC_W'(prod_reg) << {idx_reg, 4'b0000};
    assign acc_next = (cmd.clear ? '0 : acc_reg) + (vld_reg ? shifted : '0);
    assign acc      = acc_reg;

endmodule

`default_nettype wire

// File: rtl/slc_div.sv
// Restoring divider giving the quotient (dividend * 2^32) / divisor in 32 bits, one bit a cycle.
`default_nettype none

module slc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire slc_pkg::div_cmd_t         cmd,
    output logic                           done,
    output logic [slc_pkg::OUT_W-1:0]      quot
);
    import slc_pkg::*;

    localparam int STEP_W = $clog2(OUT_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] den_reg;
    logic [OUT_W-1:0]     quot_reg;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(OUT_W - 1));
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg  <= DIVISOR_W'(cmd.dividend);
            den_reg  <= cmd.divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits in its width.
            rem_reg  <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quot_reg <= {quot_reg[OUT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: rtl/slc_seq.sv
// Sequencer for gain scaling, Horner evaluation and the final divide of one pixel.
`default_nettype none

module slc_seq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [slc_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic [slc_pkg::GAIN_W-1:0]     gain,
    input  wire logic [slc_pkg::ORD_W-1:0]      order,
    input  wire slc_pkg::coef_arr_t             coefs,
    input  wire logic [slc_pkg::ACC_W-1:0]      mac_acc,
    input  wire logic                           div_done,
    input  wire logic [slc_pkg::OUT_W-1:0]      div_quot,
    input  wire logic                           res_take,
    output logic                                idle,
    output slc_pkg::mac_cmd_t                   mac_cmd,
    output slc_pkg::div_cmd_t                   div_cmd,
    output slc_pkg::slc_res_t                   res
);
    import slc_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_PMUL  = 11'b000_0000_0010,
        ST_PWAIT = 11'b000_0000_0100,
        ST_PGET  = 11'b000_0000_1000,
        ST_HADD  = 11'b000_0001_0000,
        ST_HMUL  = 11'b000_0010_0000,
        ST_HWAIT = 11'b000_0100_0000,
        ST_HGET  = 11'b000_1000_0000,
        ST_DSUM  = 11'b001_0000_0000,
        ST_DIV   = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic signed [HORNER_W-1:0] value;
        logic                       sat;
    } sat_sum_t;

    localparam logic signed [HORNER_W:0] POS_LIM = {2'b00, {(HORNER_W-1){1'b1}}};
    localparam logic signed [HORNER_W:0] NEG_LIM = -POS_LIM;
    localparam int                       PARTS   = 6;

    function automatic sat_sum_t sat_add(input logic signed [HORNER_W-1:0] a,
                                         input logic signed [HORNER_W-1:0] b);
        logic signed [HORNER_W:0] s;
        sat_sum_t                 r;
        s       = $signed({a[HORNER_W-1], a}) + $signed({b[HORNER_W-1], b});
        r.sat   = 1'b0;
        r.value = s[HORNER_W-1:0];
        if (s > POS_LIM)
        begin
            r.sat   = 1'b1;
            r.value = POS_LIM[HORNER_W-1:0];
        end
        else if (s < NEG_LIM)
        begin
            r.sat   = 1'b1;
            r.value = NEG_LIM[HORNER_W-1:0];
        end
        return r;
    endfunction

    state_t                     state_reg, state_next;
    logic [SAMPLE_W-1:0]        sample_reg, sample_next;
    logic [PROD_W-1:0]          p_reg, p_next;
    logic signed [HORNER_W-1:0] h_reg, h_next;
    logic [DIVISOR_W-1:0]       mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic [ORD_W-1:0]           k_reg, k_next;
    logic [2:0]                 part_reg, part_next;
    logic                       fault_reg, fault_next;
    logic [OUT_W-1:0]           val_reg, val_next;

    sat_sum_t                   hadd;
    sat_sum_t                   dsum;
    logic [HORNER_W-1:0]        t_abs;
    logic [ACC_W-33:0]          scaled;
    logic                       scaled_sat;
    logic [HORNER_W-1:0]        scaled_mag;
    logic                       hi_half;
    logic [1:0]                 p_sel;
    logic [MAC_B_W-1:0]         p_chunk;

    assign hadd = sat_add($signed({{(HORNER_W-COEF_W){coefs[k_reg][COEF_W-1]}}, coefs[k_reg]}),
                          h_reg);
    assign dsum = sat_add($signed({{(HORNER_W-COEF_W){coefs[0][COEF_W-1]}}, coefs[0]}),
                          h_reg);
    assign t_abs = hadd.value[HORNER_W-1] ? (HORNER_W'(0) - hadd.value) : hadd.value;

    // Product of magnitude and P, divided by 2^32 and clamped to the largest positive value.
    assign scaled     = mac_acc[ACC_W-1:32];
    assign scaled_sat = |scaled[ACC_W-33:DIVISOR_W];
    assign scaled_mag = {1'b0, scaled_sat ? {DIVISOR_W{1'b1}} : scaled[DIVISOR_W-1:0]};

    assign hi_half = part_reg >= 3'd3;
    assign p_sel   = hi_half ? 2'(part_reg - 3'd3) : part_reg[1:0];

    always_comb
    begin
        case (p_sel)
            2'd0:    p_chunk = p_reg[15:0];
            2'd1:    p_chunk = p_reg[31:16];
            default: p_chunk = p_reg[47:32];
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        sample_next = sample_reg;
        p_next      = p_reg;
        h_next      = h_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        k_next      = k_reg;
        part_next   = part_reg;
        fault_next  = fault_reg;
        val_next    = val_reg;
        mac_cmd     = '0;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = p_reg;
        div_cmd.divisor  = dsum.value[DIVISOR_W-1:0];
        res.valid   = 1'b0;
        res.fault   = fault_reg;
        res.value   = val_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sample_next = sample;
                    fault_next  = 1'b0;
                    state_next  = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_cmd.a     = gain;
                mac_cmd.b     = sample_reg;
                state_next    = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                state_next = ST_PGET;
            end
            ST_PGET:
            begin
                p_next     = mac_acc[PROD_W-1:0];
                h_next     = '0;
                k_next     = order;
                state_next = (order == '0) ? ST_DSUM : ST_HADD;
            end
            ST_HADD:
            begin
                neg_next   = hadd.value[HORNER_W-1];
                mag_next   = t_abs[DIVISOR_W-1:0];
                fault_next = fault_reg | hadd.sat;
                part_next  = '0;
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.clear = (part_reg == '0);
                mac_cmd.a     = hi_half ? MAC_A_W'(mag_reg[DIVISOR_W-1:32]) : mag_reg[31:0];
                mac_cmd.b     = p_chunk;
                mac_cmd.idx   = {1'b0, hi_half, 1'b0} + MAC_IDX_W'(p_sel);
                part_next     = part_reg + 1'b1;
                if (part_reg == 3'(PARTS - 1))
                begin
                    state_next = ST_HWAIT;
                end
            end
            ST_HWAIT:
            begin
                state_next = ST_HGET;
            end
            ST_HGET:
            begin
                h_next     = neg_reg ? $signed(HORNER_W'(0) - scaled_mag) : $signed(scaled_mag);
                fault_next = fault_reg | scaled_sat;
                k_next     = k_reg - 1'b1;
                state_next = (k_reg == ORD_W'(1)) ? ST_DSUM : ST_HADD;
            end
            ST_DSUM:
            begin
                if (dsum.value[HORNER_W-1] || (dsum.value == '0)
                    || (HORNER_W'(p_reg) >= dsum.value))
                begin
                    fault_next = 1'b1;
                    val_next   = '1;
                    state_next = ST_DONE;
                end
                else
                begin
                    fault_next    = fault_reg | dsum.sat;
                    div_cmd.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    val_next   = div_quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res.valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            part_reg  <= '0;
            fault_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            part_reg  <= part_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        p_reg      <= p_next;
        h_reg      <= h_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        val_reg    <= val_next;
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/spectrum_linearity_corrector.sv
// Top level: byte framing, configuration registers, output register and the pixel datapath.
//
//  channel   handshake                  payload
//  in        in_valid / in_ready        raw_byte, frame_start, frame_end
//  out       out_valid / out_ready      corrected_intensity, pixel_index, last_pixel, range_fault
//  cfg       cfg_wr_en                  cfg_wr_index, cfg_wr_data
//
// A byte that completes no pixel leaves in_ready high. A byte that completes a pixel keeps in_ready
// low while the datapath runs one pass of the shared 32x16 multiplier for the gain, six passes per
// Horner term and the one-bit-a-cycle divider, which is skipped when the result saturates, and
// until the result is loaded into the output register. Reset is asynchronous and restores the
// register defaults. A result waits in the output register while the next byte is taken; the
// datapath holds its finished pixel while the output register is still full.
`default_nettype none

module spectrum_linearity_corrector #(
    parameter int MAX_PIXELS    = slc_pkg::MAX_PIXELS_DEF,
    parameter int SYNC_INTERVAL = slc_pkg::SYNC_INTERVAL_DEF,
    parameter int MAX_ORDER     = slc_pkg::MAX_ORDER_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [slc_pkg::BYTE_W-1:0]      raw_byte,
    input  wire logic                            frame_start,
    input  wire logic                            frame_end,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [slc_pkg::OUT_W-1:0]            corrected_intensity,
    output logic [slc_pkg::PIX_IDX_W-1:0]        pixel_index,
    output logic                                 last_pixel,
    output logic                                 range_fault,
    input  wire logic                            cfg_wr_en,
    input  wire logic [slc_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [slc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import slc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int SYNC_W = $clog2(SYNC_INTERVAL);

    // Configuration registers
    logic [GAIN_W-1:0]   gain_reg;
    logic [PIXCNT_W-1:0] pixcnt_reg;
    logic [ORD_W-1:0]    ord_reg;
    coef_arr_t           coef_reg;

    // Framing state
    logic [BYTE_W-1:0]   low_reg, low_next;
    logic                phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SYNC_W-1:0]   sync_reg, sync_next;
    logic                skip_reg, skip_next;
    logic                done_reg, done_next;

    logic [CNT_W-1:0]    limit;
    logic [ORD_W-1:0]    ord_eff;
    logic                in_fire;
    logic                emit;
    logic [CNT_W-1:0]    pix_pos;
    logic [CNT_W-1:0]    cnt_inc;
    logic [SAMPLE_W-1:0] sample;

    logic [CNT_W-1:0]    pos_hold_reg;
    logic                last_hold_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_val_reg;
    logic [CNT_W-1:0]    out_pos_reg;
    logic                out_last_reg;
    logic                out_fault_reg;
    logic                load;

    logic                seq_idle;
    mac_cmd_t            mac_cmd;
    div_cmd_t            div_cmd;
    slc_res_t            res;
    logic [ACC_W-1:0]    mac_acc;
    logic                div_done;
    logic [OUT_W-1:0]    div_quot;

    assign limit   = (32'(pixcnt_reg) > 32'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                           : CNT_W'(pixcnt_reg);
    assign ord_eff = (32'(ord_reg) > 32'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ord_reg;
    assign in_ready = seq_idle;
    assign in_fire  = in_valid && in_ready;
    assign sample   = {raw_byte ^ 8'h80, low_reg};
    assign cnt_inc  = pix_pos + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RST;
            pixcnt_reg <= PIXCNT_RST;
            ord_reg    <= ORD_RST;
            coef_reg   <= {{((NUM_COEFS - 1) * COEF_W){1'b0}}, COEF0_RST};
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                REG_SCALE_GAIN:  gain_reg    <= cfg_wr_data[GAIN_W-1:0];
                REG_PIXEL_COUNT: pixcnt_reg  <= cfg_wr_data[PIXCNT_W-1:0];
                REG_POLY_ORDER:  ord_reg     <= cfg_wr_data[ORD_W-1:0];
                REG_COEF_0:      coef_reg[0] <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_1:      coef_reg[1] <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_2:      coef_reg[2] <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_3:      coef_reg[3] <= cfg_wr_data[COEF_W-1:0];
                REG_COEF_4:      coef_reg[4] <= cfg_wr_data[COEF_W-1:0];
                default:         gain_reg    <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        low_next   = low_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sync_next  = sync_reg;
        skip_next  = skip_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        pix_pos    = cnt_reg;
        if (in_fire)
        begin
            if (frame_start)
            begin
                phase_next = 1'b0;
                cnt_next   = '0;
                sync_next  = '0;
                skip_next  = 1'b0;
                done_next  = 1'b0;
            end
            pix_pos = cnt_next;
            if (!done_next)
            begin
                if (cnt_next >= limit)
                begin
                    done_next = 1'b1;
                end
                else if (skip_next)
                begin
                    // The sync byte after a full block of pixels is dropped.
                    skip_next = 1'b0;
                end
                else if (!phase_next)
                begin
                    low_next   = raw_byte;
                    phase_next = 1'b1;
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = 1'b0;
                    cnt_next   = cnt_inc;
                    sync_next  = (sync_next == SYNC_W'(SYNC_INTERVAL - 1)) ? '0
                                                                          : sync_next + 1'b1;
                    if (cnt_inc >= limit)
                    begin
                        done_next = 1'b1;
                    end
                    else if (sync_next == '0)
                    begin
                        skip_next = 1'b1;
                    end
                end
            end
            if (frame_end)
            begin
                phase_next = 1'b0;
                skip_next  = 1'b0;
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= '0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            sync_reg  <= '0;
            skip_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            low_reg   <= low_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sync_reg  <= sync_next;
            skip_reg  <= skip_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pos_hold_reg  <= pix_pos;
            last_hold_reg <= (cnt_inc == limit);
        end
    end

    slc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (mac_acc)
    );

    slc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .done  (div_done),
        .quot  (div_quot)
    );

    slc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (emit),
        .sample   (sample),
        .gain     (gain_reg),
        .order    (ord_eff),
        .coefs    (coef_reg),
        .mac_acc  (mac_acc),
        .div_done (div_done),
        .div_quot (div_quot),
        .res_take (load),
        .idle     (seq_idle),
        .mac_cmd  (mac_cmd),
        .div_cmd  (div_cmd),
        .res      (res)
    );

    assign load = res.valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_val_reg   <= res.value;
            out_fault_reg <= res.fault;
            out_pos_reg   <= pos_hold_reg;
            out_last_reg  <= last_hold_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign corrected_intensity = out_val_reg;
    assign pixel_index         = PIX_IDX_W'(out_pos_reg);
    assign last_pixel          = out_last_reg;
    assign range_fault         = out_fault_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the spectrum linearity corrector, with a bit-exact pixel predictor.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slc_pkg::*;

    localparam longint SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [OUT_W-1:0]     value;
        logic [PIX_IDX_W-1:0] index;
        logic                 last;
        logic                 fault;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     raw_byte;
    logic                  frame_start;
    logic                  frame_end;
    logic                  out_valid;
    logic                  out_ready;
    logic [OUT_W-1:0]      corrected_intensity;
    logic [PIX_IDX_W-1:0]  pixel_index;
    logic                  last_pixel;
    logic                  range_fault;
    logic                  cfg_wr_en;
    cfg_reg_t              cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Predictor copy of the registers and the framing state.
    logic [GAIN_W-1:0]   gain_reg;
    logic [PIXCNT_W-1:0] pix_limit_reg;
    logic [ORD_W-1:0]    order_reg;
    longint              coef_reg [NUM_COEFS];
    logic [BYTE_W-1:0]   low_hold;
    bit                  high_next;
    int                  pix_done;
    bit                  sync_skip;
    bit                  frame_over;
    bit                  calc_fault;

    pixel_t expected_pixels [$];
    int     live_bytes;
    int     mismatches;
    int     stall_left;
    bit     idle_on;

    spectrum_linearity_corrector dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .raw_byte            (raw_byte),
        .frame_start         (frame_start),
        .frame_end           (frame_end),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .corrected_intensity (corrected_intensity),
        .pixel_index         (pixel_index),
        .last_pixel          (last_pixel),
        .range_fault         (range_fault),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_sum(input longint a, input longint b);
        if (b > 0 && a > SAT_MAX - b)
        begin
            calc_fault = 1'b1;
            return SAT_MAX;
        end
        if (b < 0 && a < -SAT_MAX - b)
        begin
            calc_fault = 1'b1;
            return -SAT_MAX;
        end
        return a + b;
    endfunction

    // Signed t times p over 2^32, magnitude truncated towards zero and clamped.
    function automatic longint horner_scale(input longint t, input logic [PROD_W-1:0] p);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  r;
        mag  = (t < 0) ? 64'(-t) : 64'(t);
        prod = (128'(mag) * 128'(p)) >> 32;
        if (prod > 128'(SAT_MAX))
        begin
            calc_fault = 1'b1;
            r = SAT_MAX;
        end
        else
            r = prod[63:0];
        return (t < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [OUT_W-1:0] corrected_value(input logic [SAMPLE_W-1:0] sample);
        logic [PROD_W-1:0] p;
        logic [127:0]      quo;
        longint            acc;
        longint            den;
        int                ord;
        p   = 48'(sample) * 48'(gain_reg);
        ord = (order_reg > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(order_reg);
        acc = 0;
        for (int k = ord; k > 0; k--)
            acc = horner_scale(clamp_sum(coef_reg[k], acc), p);
        den = clamp_sum(coef_reg[0], acc);
        if (den <= 0 || {16'd0, p} >= unsigned'(den))
        begin
            calc_fault = 1'b1;
            return '1;
        end
        quo = ({80'd0, p} << 32) / {64'd0, den};
        return quo[OUT_W-1:0];
    endfunction

    function automatic void reset_model();
        gain_reg      = GAIN_RST;
        pix_limit_reg = PIXCNT_RST;
        order_reg     = ORD_RST;
        coef_reg[0]   = longint'($signed(COEF0_RST));
        for (int k = 1; k < NUM_COEFS; k++)
            coef_reg[k] = 0;
        low_hold   = '0;
        high_next  = 1'b0;
        pix_done   = 0;
        sync_skip  = 1'b0;
        frame_over = 1'b0;
    endfunction

    function automatic void note_config(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_SCALE_GAIN:  gain_reg = d[GAIN_W-1:0];
            REG_PIXEL_COUNT: pix_limit_reg = d[PIXCNT_W-1:0];
            REG_POLY_ORDER:  order_reg = d[ORD_W-1:0];
            default:         coef_reg[idx - REG_COEF_0] = longint'($signed(d[COEF_W-1:0]));
        endcase
    endfunction

    function automatic int frame_limit();
        return (pix_limit_reg > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : int'(pix_limit_reg);
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] b, input bit fs, input bit fe);
        pixel_t px;
        int     lim;
        lim = frame_limit();
        if (fs)
        begin
            high_next  = 1'b0;
            pix_done   = 0;
            sync_skip  = 1'b0;
            frame_over = 1'b0;
        end
        if (!frame_over)
        begin
            live_bytes++;
            if (pix_done >= lim)
                frame_over = 1'b1;
            else if (sync_skip)
                sync_skip = 1'b0;
            else if (!high_next)
            begin
                low_hold  = b;
                high_next = 1'b1;
            end
            else
            begin
                calc_fault = 1'b0;
                px.value   = corrected_value({b, low_hold} ^ 16'h8000);
                px.index   = pix_done[PIX_IDX_W-1:0];
                px.last    = (pix_done + 1 == lim);
                px.fault   = calc_fault;
                expected_pixels.push_back(px);
                high_next = 1'b0;
                pix_done++;
                if (pix_done >= lim)
                    frame_over = 1'b1;
                else if (pix_done % SYNC_INTERVAL_DEF == 0)
                    sync_skip = 1'b1;
            end
        end
        if (fe)
        begin
            high_next  = 1'b0;
            sync_skip  = 1'b0;
            frame_over = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- result checking

    task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected pixel, expected none, got value 0x%0h index %0d",
                         $time, corrected_intensity, pixel_index);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (corrected_intensity !== want.value)
                    flag_field("corrected_intensity", 64'(want.value),
                               64'(corrected_intensity));
                if (pixel_index !== want.index)
                    flag_field("pixel_index", 64'(want.index), 64'(pixel_index));
                if (last_pixel !== want.last)
                    flag_field("last_pixel", 64'(want.last), 64'(last_pixel));
                if (range_fault !== want.fault)
                    flag_field("range_fault", 64'(want.fault), 64'(range_fault));
            end
        end
    end

    // Output back-pressure comes in random bursts while idle_on is set.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end
        else
            out_ready <= 1'b1;
    end

    // ---------------------------------------------------------------- drivers

    function automatic logic [CFG_DATA_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit fs, input bit fe);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        raw_byte    <= b;
        frame_start <= fs;
        frame_end   <= fe;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b, fs, fe);
        @(negedge clk);
    endtask

    task automatic push_pair(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi,
                             input bit fs);
        push_byte(lo, fs, 1'b0);
        push_byte(hi, 1'b0, 1'b0);
    endtask

    // Registers may only change once the datapath has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= d;
        note_config(idx, d);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_coef(input int k, input logic [CFG_DATA_W-1:0] d);
        cfg_write(cfg_reg_t'(REG_COEF_0 + k), d);
    endtask

    task automatic shuffle_config(input bit write_all);
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] r;
        logic [GAIN_W-1:0]     g;
        logic [PIXCNT_W-1:0]   pc;
        hi = rand48();
        if (write_all || $urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 7))
                0:       g = 32'h0001_0000;
                1:       g = 32'hFFFF_FFFF;
                2:       g = $urandom;
                3:       g = '0;
                default: g = $urandom_range(32'h0001_0000, 32'h0004_0000);
            endcase
            cfg_write(REG_SCALE_GAIN, {hi[47:32], g});
        end
        if (write_all || $urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 15))
                0:       pc = '0;
                1:       pc = '1;
                2:       pc = PIXCNT_W'(MAX_PIXELS_DEF);
                default: pc = PIXCNT_W'($urandom_range(1, 12));
            endcase
            cfg_write(REG_PIXEL_COUNT, {hi[47:11], pc});
        end
        if (write_all || $urandom_range(0, 3) != 0)
            cfg_write(REG_POLY_ORDER, {hi[47:3], 3'($urandom_range(0, 7))});
        for (int k = 0; k < NUM_COEFS; k++)
        begin
            r = rand48();
            if (write_all || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 11))
                    0:       set_coef(k, 48'h7FFF_FFFF_FFFF);
                    1:       set_coef(k, 48'h8000_0000_0000);
                    2:       set_coef(k, r);
                    3:       set_coef(k, '0);
                    default:
                        // Mostly near unity for the constant term and small for the rest.
                        if (k == 0)
                            set_coef(k, COEF0_RST + {{9{r[38]}}, r[38:0]});
                        else
                            set_coef(k, {{11{r[36]}}, r[36:0]});
                endcase
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        push_pair(8'h00, 8'h80, 1'b0);
        push_pair(8'hFF, 8'h7F, 1'b0);
        push_pair(8'hFF, 8'hFF, 1'b0);
        push_pair(8'h00, 8'h00, 1'b0);
        push_pair(8'h34, 8'h12, 1'b0);
    endtask

    task automatic test_range_faults();
        settle();
        set_coef(0, '0);
        push_pair(8'h21, 8'h43, 1'b1);
        settle();
        set_coef(0, 48'h8000_0000_0000);
        push_pair(8'hFF, 8'hFF, 1'b1);
        settle();
        set_coef(0, COEF0_RST);
        cfg_write(REG_SCALE_GAIN, 48'hFFFF_FFFF_FFFF);
        push_pair(8'hFF, 8'h7F, 1'b1);
        push_pair(8'h00, 8'h80, 1'b0);
    endtask

    task automatic test_horner_saturation();
        settle();
        cfg_write(REG_POLY_ORDER, 48'd4);
        for (int k = 1; k < NUM_COEFS; k++)
            set_coef(k, 48'h7FFF_FFFF_FFFF);
        push_pair(8'hFF, 8'h7F, 1'b1);
        push_pair(8'h00, 8'h80, 1'b0);
        settle();
        // Orders above the maximum behave as the maximum.
        cfg_write(REG_POLY_ORDER, 48'd7);
        for (int k = 1; k < NUM_COEFS; k++)
            set_coef(k, 48'h8000_0000_0000);
        push_pair(8'hFF, 8'h7F, 1'b1);
        push_pair(8'h01, 8'h80, 1'b0);
    endtask

    task automatic test_frame_control();
        settle();
        cfg_write(REG_SCALE_GAIN, 48'h1_0000);
        cfg_write(REG_POLY_ORDER, 48'd0);
        cfg_write(REG_PIXEL_COUNT, 48'd3);
        push_pair(8'h11, 8'h22, 1'b1);
        push_pair(8'h33, 8'h44, 1'b0);
        push_pair(8'h55, 8'h66, 1'b0);
        push_byte(8'h77, 1'b0, 1'b0);
        push_byte(8'h88, 1'b0, 1'b0);
        // A new frame start in mid-pixel throws away the held low byte.
        push_pair(8'h99, 8'hAA, 1'b1);
        push_byte(8'hBB, 1'b0, 1'b0);
        push_pair(8'hCC, 8'hDD, 1'b1);
        push_byte(8'hEE, 1'b0, 1'b1);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h02, 1'b1, 1'b1);
        push_byte(8'h03, 1'b0, 1'b0);
        settle();
        cfg_write(REG_PIXEL_COUNT, 48'd0);
        push_pair(8'h04, 8'h05, 1'b1);
        push_byte(8'h06, 1'b0, 1'b0);
    endtask

    // A frame longer than the sync interval is needed to reach the dropped sync byte.
    task automatic test_sync_byte();
        int n;
        idle_on = 1'b0;
        settle();
        shuffle_config(1'b1);
        settle();
        cfg_write(REG_SCALE_GAIN, 48'h1_0000);
        cfg_write(REG_POLY_ORDER, 48'($urandom_range(0, 2)));
        set_coef(0, COEF0_RST);
        cfg_write(REG_PIXEL_COUNT, 48'h7FF);
        n = 2 * SYNC_INTERVAL_DEF + 9;
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), i == 0, i == n - 1);
        push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int goal;
        int lim;
        int n;
        bit fs;
        bit fe;
        bit first;
        goal  = live_bytes + 600;
        first = 1'b1;
        while (live_bytes < goal)
        begin
            settle();
            shuffle_config(first);
            first   = 1'b0;
            idle_on = (goal - live_bytes > 150) && ($urandom_range(0, 3) != 0);
            lim     = frame_limit();
            n       = 2 * lim + $urandom_range(0, 3);
            if (n > 40)
                n = 40 - $urandom_range(0, 1);
            for (int i = 0; i < n; i++)
            begin
                fs = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 79) == 0);
                fe = ($urandom_range(0, 119) == 0) || (i == n - 1 && $urandom_range(0, 2) == 0);
                push_byte(8'($urandom_range(0, 255)), fs, fe);
            end
        end
        idle_on = 1'b0;
        settle();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        raw_byte     = '0;
        frame_start  = 1'b0;
        frame_end    = 1'b0;
        out_ready    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_SCALE_GAIN;
        cfg_wr_data  = '0;
        stall_left   = 0;
        idle_on      = 1'b1;
        live_bytes   = 0;
        mismatches   = 0;
        reset_model();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_range_faults();
        test_horner_saturation();
        test_frame_control();
        test_sync_byte();
        test_random_frames();

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/slc_pkg.sv
rtl/slc_mac.sv
rtl/slc_div.sv
rtl/slc_seq.sv
rtl/spectrum_linearity_corrector.sv
tb/tb_top.sv
